[rtl/assert_macros.svh]
// assertion macros for the button press event queue checker
// needs a clk and an active-low rst_n in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define BPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every rising edge, reset included
`define BPQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bpq_pkg.sv]
// shared types and constants of the button press event queue
// no dependencies
`timescale 1ns / 1ps

package bpq_pkg;

  localparam int KEY_W   = 8;
  localparam int TICK_W  = 9;
  localparam int CNT_W   = 10;
  localparam int WORD_W  = 19;
  localparam int CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] CODE_REPEAT_EARLY = 19'h10000;
  localparam logic [WORD_W-1:0] CODE_REPEAT_LATE  = 19'h40000;
  localparam logic [CNT_W-1:0]  COUNT_MAX         = 10'd1023;

  // register reset values
  localparam logic [KEY_W-1:0]  KEY_CODE_RST  = 8'd1;
  localparam logic [KEY_W-1:0]  PRESS_MIN_RST = 8'd2;
  localparam logic [TICK_W-1:0] HOLD_RST      = 9'd200;
  localparam logic [TICK_W-1:0] REPEAT_RST    = 9'd100;
  // 0 mod 100 and 200 mod 100
  localparam logic [TICK_W-1:0] PHASE_RST     = 9'd0;
  localparam logic [TICK_W-1:0] HOLD_MOD_RST  = 9'd0;

  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_READ    = 1'b1;
  localparam logic PIN_PRESSED = 1'b0;

  // remainder unit: one dividend bit per cycle
  localparam int MOD_STEPS  = CNT_W;
  localparam int MOD_STEP_W = $clog2(MOD_STEPS + 1);

  // queues between and after the two halves
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_CODE     = 2'd0,
    CFG_PRESS_MIN    = 2'd1,
    CFG_HOLD_TICKS   = 2'd2,
    CFG_REPEAT_TICKS = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SHORT = 2'd1,
    MODE_LONG  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    RC_IDLE = 2'd0,
    RC_CNT  = 2'd1,
    RC_HOLD = 2'd2
  } rc_state_t;

  typedef struct packed {
    logic              is_read;
    logic              push_en;
    logic [WORD_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] key_word;
    logic              was_empty;
  } res_t;

endpackage

[rtl/bpq_mod_unit.sv]
// iterative remainder unit, one restoring step per cycle
// depends on bpq_pkg
`timescale 1ns / 1ps

module bpq_mod_unit import bpq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CNT_W-1:0]  dividend,
  input  logic [TICK_W-1:0] divisor,
  output logic              done,
  output logic [TICK_W-1:0] rem
);

  logic                  busy_r;
  logic                  done_r;
  logic [MOD_STEP_W-1:0] step_r;
  logic [CNT_W-1:0]      quo_r;
  logic [TICK_W-1:0]     rem_r;
  logic [TICK_W-1:0]     div_r;
  logic [CNT_W-1:0]      trial;
  logic [TICK_W-1:0]     rem_nxt;

  always_comb begin
    trial = {rem_r, quo_r[CNT_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = TICK_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == MOD_STEP_W'(1));
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= MOD_STEP_W'(MOD_STEPS);
      end else if (busy_r) begin
        step_r <= step_r - MOD_STEP_W'(1);
        if (step_r == MOD_STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[CNT_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[rtl/bpq_front.sv]
// front half: config registers, press mode tracking and event classification
// depends on bpq_pkg and bpq_mod_unit
`timescale 1ns / 1ps

module bpq_front import bpq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  input  logic                 acc,
  input  logic                 req_type,
  input  logic                 pin_level,
  output logic                 busy,
  output cmd_t                 cmd
);

  logic [KEY_W-1:0]  key_code_r;
  logic [KEY_W-1:0]  press_min_r;
  logic [TICK_W-1:0] hold_ticks_r;
  logic [TICK_W-1:0] repeat_ticks_r;

  mode_t             mode_r, mode_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TICK_W-1:0] phase_r, phase_nxt;
  logic [TICK_W-1:0] hold_mod_r, hold_mod_nxt;
  rc_state_t         rc_r, rc_nxt;
  logic              recalc_r, recalc_nxt;

  logic              mod_start;
  logic [CNT_W-1:0]  mod_dividend;
  logic              mod_done;
  logic [TICK_W-1:0] mod_rem;

  logic [CNT_W-1:0]  phase_inc;
  logic [TICK_W-1:0] cphase;
  logic [CNT_W:0]    cnt_inc;
  logic [CNT_W:0]    lim;
  logic [CNT_W-1:0]  dm_wide;
  logic [TICK_W-1:0] dm;
  logic [CNT_W-1:0]  folded;
  logic              early;
  logic [WORD_W-1:0] word;
  cfg_idx_t          idx;

  assign idx = cfg_idx_t'(cfg_index);

  bpq_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (repeat_ticks_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // count and phase arithmetic, phase is count mod repeat period
  always_comb begin
    phase_inc = {1'b0, phase_r} + CNT_W'(1);
    if (phase_inc == {1'b0, repeat_ticks_r}) begin
      cphase = '0;
    end else begin
      cphase = phase_inc[TICK_W-1:0];
    end
    cnt_inc = {1'b0, count_r} + (CNT_W+1)'(1);
    lim     = {2'b00, hold_ticks_r} + {2'b00, repeat_ticks_r};
    if (cphase >= hold_mod_r) begin
      dm_wide = {1'b0, cphase} - {1'b0, hold_mod_r};
    end else begin
      dm_wide = {1'b0, cphase} + {1'b0, repeat_ticks_r} - {1'b0, hold_mod_r};
    end
    dm     = dm_wide[TICK_W-1:0];
    folded = {1'b0, hold_ticks_r} + {1'b0, dm};
  end

  // press mode machine
  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    phase_nxt = phase_r;
    word      = '0;
    early     = 1'b0;
    if (acc && (req_type == REQ_TICK)) begin
      if (pin_level == PIN_PRESSED) begin
        if ((mode_r == MODE_LONG) && (repeat_ticks_r != '0)) begin
          if (cnt_inc >= lim) begin
            count_nxt = folded;
          end else begin
            count_nxt = cnt_inc[CNT_W-1:0];
            early     = cnt_inc < {2'b00, hold_ticks_r};
          end
          phase_nxt = cphase;
          if (cphase == '0) begin
            word = (early ? CODE_REPEAT_EARLY : CODE_REPEAT_LATE)
                   | {{(WORD_W-KEY_W){1'b0}}, key_code_r};
          end
        end else begin
          if (count_r != COUNT_MAX) begin
            count_nxt = cnt_inc[CNT_W-1:0];
            phase_nxt = cphase;
          end
          unique case (mode_r)
            MODE_IDLE: begin
              if ((count_nxt > {2'b00, press_min_r}) &&
                  (count_nxt < {1'b0, hold_ticks_r})) begin
                mode_nxt = MODE_SHORT;
              end
            end
            MODE_SHORT: begin
              if (count_nxt >= {1'b0, hold_ticks_r}) begin
                mode_nxt  = MODE_LONG;
                count_nxt = '0;
                phase_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end else begin
        if (mode_r == MODE_SHORT) begin
          word = {{(WORD_W-KEY_W){1'b0}}, key_code_r};
        end
        mode_nxt  = MODE_IDLE;
        count_nxt = '0;
        phase_nxt = '0;
      end
    end
  end

  // recompute count mod period and hold mod period after a hold or period write
  always_comb begin
    rc_nxt       = rc_r;
    recalc_nxt   = recalc_r;
    hold_mod_nxt = hold_mod_r;
    mod_start    = 1'b0;
    mod_dividend = count_r;
    unique case (rc_r)
      RC_IDLE: begin
        if (recalc_r) begin
          mod_start  = 1'b1;
          recalc_nxt = 1'b0;
          rc_nxt     = RC_CNT;
        end
      end
      RC_CNT: begin
        if (mod_done) begin
          mod_start    = 1'b1;
          mod_dividend = {1'b0, hold_ticks_r};
          rc_nxt       = RC_HOLD;
        end
      end
      RC_HOLD: begin
        if (mod_done) begin
          hold_mod_nxt = mod_rem;
          rc_nxt       = RC_IDLE;
        end
      end
      default: begin
        rc_nxt = RC_IDLE;
      end
    endcase
    if (cfg_wr && ((idx == CFG_HOLD_TICKS) || (idx == CFG_REPEAT_TICKS))) begin
      recalc_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_code_r     <= KEY_CODE_RST;
      press_min_r    <= PRESS_MIN_RST;
      hold_ticks_r   <= HOLD_RST;
      repeat_ticks_r <= REPEAT_RST;
      mode_r         <= MODE_IDLE;
      count_r        <= '0;
      phase_r        <= PHASE_RST;
      hold_mod_r     <= HOLD_MOD_RST;
      rc_r           <= RC_IDLE;
      recalc_r       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (idx)
          CFG_KEY_CODE:     key_code_r     <= cfg_data[KEY_W-1:0];
          CFG_PRESS_MIN:    press_min_r    <= cfg_data[KEY_W-1:0];
          CFG_HOLD_TICKS:   hold_ticks_r   <= cfg_data;
          CFG_REPEAT_TICKS: repeat_ticks_r <= cfg_data;
          default: begin
          end
        endcase
      end
      mode_r     <= mode_nxt;
      count_r    <= count_nxt;
      phase_r    <= ((rc_r == RC_CNT) && mod_done) ? mod_rem : phase_nxt;
      hold_mod_r <= hold_mod_nxt;
      rc_r       <= rc_nxt;
      recalc_r   <= recalc_nxt;
    end
  end

  assign busy         = recalc_r || (rc_r != RC_IDLE);
  assign cmd.is_read  = (req_type == REQ_READ);
  assign cmd.push_en  = (word != '0);
  assign cmd.word     = word;

endmodule

[rtl/bpq_fifo.sv]
// small register fifo used between and after the two halves
// no dependencies
`timescale 1ns / 1ps

module bpq_fifo #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

[rtl/bpq_back.sv]
// back half: event ring memory, pops and result formation
// depends on bpq_pkg
`timescale 1ns / 1ps

module bpq_back import bpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_empty,
  input  cmd_t                 cmd,
  output logic                 cmd_pop,
  input  logic [OUT_CNT_W-1:0] out_count,
  output logic                 res_push,
  output res_t                 res
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [WORD_W-1:0] event_store_r [QUEUE_DEPTH];
  logic [WORD_W-1:0] mem_q_r;
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic              b2_valid_r;
  logic              b2_is_read_r;
  logic              b2_empty_r;
  logic [OUT_CNT_W:0] pending;
  logic              issue;
  logic              ring_empty;
  logic              mem_we, mem_re;

  // reserve an output slot for the result still in the read stage
  assign pending    = {1'b0, out_count} + (OUT_CNT_W+1)'(b2_valid_r);
  assign issue      = !cmd_empty && (pending < (OUT_CNT_W+1)'(OUT_DEPTH));
  assign ring_empty = (rd_ptr_r == wr_ptr_r);
  assign mem_we     = issue && !cmd.is_read && cmd.push_en;
  assign mem_re     = issue && cmd.is_read && !ring_empty;
  assign cmd_pop    = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      b2_valid_r <= 1'b0;
    end else begin
      b2_valid_r <= issue;
      if (mem_we) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (mem_re) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      event_store_r[wr_ptr_r] <= cmd.word;
    end
    if (mem_re) begin
      mem_q_r <= event_store_r[rd_ptr_r];
    end
    if (issue) begin
      b2_is_read_r <= cmd.is_read;
      b2_empty_r   <= ring_empty;
    end
  end

  assign res_push      = b2_valid_r;
  assign res.key_word  = (b2_is_read_r && !b2_empty_r) ? mem_q_r : '0;
  assign res.was_empty = b2_is_read_r && b2_empty_r;

endmodule

[rtl/button_press_event_queue_top.sv]
// top level of the button press event queue: front, command fifo, back, result fifo
// depends on bpq_pkg, bpq_front, bpq_mod_unit, bpq_fifo and bpq_back
`timescale 1ns / 1ps

// One input item (a tick carrying a pin sample, or a read) is taken per clock
// while in_full is low, and gives exactly one result. Ticks return a zero
// word; reads pop the oldest queued key event or report an empty queue. Each
// item passes the command fifo, the ring access with registered ring read and
// the result fifo write before its result shows on the out_ ports. A
// write to hold_ticks or repeat_ticks starts a remainder recompute in the
// bit-serial unit of the front: in_full stays high after that write until
// both ten-step passes (count, then hold) and their hand-over are done, and a
// second such write while it runs starts one more full recompute. Writes to
// the other registers cost nothing. The event ring needs no clearing pass
// after reset. cfg_ready is always high.
module button_press_event_queue_top import bpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_req_type,
  input  logic                 in_pin_level,
  // result channel
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [WORD_W-1:0]    out_key_word,
  output logic                 out_was_empty,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  logic                 in_acc;
  logic                 front_busy;
  cmd_t                 front_cmd;
  cmd_t                 cmd_head;
  logic                 cmd_full;
  logic                 cmd_empty;
  logic                 cmd_pop;
  logic                 res_push;
  res_t                 res;
  res_t                 out_head;
  logic [OUT_CNT_W-1:0] out_count;

  // config port never stalls
  assign cfg_ready = 1'b1;

  // input transfer when the command fifo has room and no recompute runs
  assign in_full = cmd_full || front_busy;
  assign in_acc  = in_push && !in_full;

  // front updates press state at the input transfer and emits one command
  bpq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (in_acc),
    .req_type  (in_req_type),
    .pin_level (in_pin_level),
    .busy      (front_busy),
    .cmd       (front_cmd)
  );

  // short decoupling queue between the two halves
  bpq_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_acc),
    .din   (front_cmd),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .full  (cmd_full),
    .empty (cmd_empty),
    .count ()
  );

  // back writes queued events and serves reads in command order
  bpq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue, its head is what the out_ ports show
  bpq_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .pop   (out_pop),
    .dout  (out_head),
    .full  (),
    .empty (out_empty),
    .count (out_count)
  );

  assign out_key_word  = out_head.key_word;
  assign out_was_empty = out_head.was_empty;

endmodule

[rtl/bpq_checker.sv]
// port-level checker for the button press event queue, bound to the top level
// depends on bpq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpq_checker import bpq_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input logic [WORD_W-1:0] out_key_word,
  input logic              out_was_empty
);

  // both queues come out of reset drained and ready
  `BPQ_ASSERT_RST(reset_drains, !rst_n |=> out_empty && !in_full, "not drained after reset")

  // an empty read carries no event word
  `BPQ_ASSERT(empty_read_zero, !out_empty && out_was_empty |-> out_key_word == '0, "empty read has word")

  // event words are a key code, or an early or late repeat code with a key
  `BPQ_ASSERT(word_code_legal, !out_empty |-> !out_key_word[17] && !(out_key_word[16] && out_key_word[18]), "bad event code")

  // a waiting result stays until its transfer
  `BPQ_ASSERT(result_held, !out_empty && !out_pop |=> !out_empty, "result dropped")

endmodule

bind button_press_event_queue_top bpq_checker u_bpq_checker (.*);

[tb/button_press_event_queue_top_tb.sv]
// self-checking testbench for button_press_event_queue_top: button ticks, long press, repeat, reads
// depends on bpq_pkg and the rtl of the block; nothing else
`timescale 1ns / 1ps

module button_press_event_queue_top_tb;
  import bpq_pkg::*;

  localparam int DEPTH = 16;
  localparam logic PIN_RELEASED = ~PIN_PRESSED;

  // one request as the sender sees it
  typedef struct packed {
    logic req;
    logic pin;
  } button_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic                 in_req_type = REQ_TICK;
  logic                 in_pin_level = PIN_RELEASED;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [WORD_W-1:0]    out_key_word;
  logic                 out_was_empty;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY_CODE;
  logic [TICK_W-1:0]    cfg_data = '0;

  button_press_event_queue_top #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_req_type  (in_req_type),
    .in_pin_level (in_pin_level),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_key_word (out_key_word),
    .out_was_empty(out_was_empty),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // requests waiting for the driver, results waiting for the monitor
  button_req_t pending_reqs[$];
  res_t        pending_results[$];

  // idle rates in percent, changed between phases
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // shadow of the register file
  logic [KEY_W-1:0]  key_sh;
  logic [KEY_W-1:0]  pmin_sh;
  logic [TICK_W-1:0] hold_sh;
  logic [TICK_W-1:0] rpt_sh;

  // shadow of the button state and the event ring
  mode_t             cur_mode;
  int unsigned       held;
  logic [WORD_W-1:0] ev_ring[DEPTH];
  int unsigned       ring_rd;
  int unsigned       ring_wr;

  // bookkeeping for the summary
  int n_errors = 0;
  int n_results = 0;
  int n_events = 0;
  int n_empty = 0;
  int n_wraps = 0;
  int n_settings = 0;
  int n_queued = 0;
  int n_taken = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("simulation failed");
    $finish;
  end

  function automatic void reset_shadow();
    key_sh   = KEY_CODE_RST;
    pmin_sh  = PRESS_MIN_RST;
    hold_sh  = HOLD_RST;
    rpt_sh   = REPEAT_RST;
    cur_mode = MODE_IDLE;
    held     = 0;
    ring_rd  = 0;
    ring_wr  = 0;
  endfunction

  // advances the button and ring shadow by one request and queues the result it gives
  function automatic void predict_event_word(logic req, logic pin);
    logic [WORD_W-1:0] word;
    res_t              res;
    int unsigned       hold_n;
    int unsigned       rpt_n;
    word   = '0;
    res    = '0;
    hold_n = hold_sh;
    rpt_n  = rpt_sh;
    if (req == REQ_TICK) begin
      if (pin == PIN_PRESSED) begin
        if (cur_mode == MODE_LONG && rpt_n != 0) begin
          held++;
          // fold the counter back by whole repeat periods
          if (held >= hold_n + rpt_n)
            held = hold_n + (held - hold_n) % rpt_n;
          if (held % rpt_n == 0)
            word = (held < hold_n ? CODE_REPEAT_EARLY : CODE_REPEAT_LATE) | WORD_W'(key_sh);
        end else begin
          if (held < COUNT_MAX)
            held++;
          if (cur_mode == MODE_IDLE) begin
            if (held > pmin_sh && held < hold_n)
              cur_mode = MODE_SHORT;
          end else if (cur_mode == MODE_SHORT) begin
            if (held >= hold_n) begin
              cur_mode = MODE_LONG;
              held = 0;
            end
          end
        end
      end else begin
        // short press reports its key on release
        if (cur_mode == MODE_SHORT)
          word = WORD_W'(key_sh);
        cur_mode = MODE_IDLE;
        held = 0;
      end
      if (word != '0) begin
        ev_ring[ring_wr] = word;
        ring_wr = (ring_wr + 1) % DEPTH;
        if (ring_wr == ring_rd)
          n_wraps++;
      end
    end else if (ring_rd == ring_wr) begin
      res.was_empty = 1'b1;
      n_empty++;
    end else begin
      res.key_word = ev_ring[ring_rd];
      ring_rd = (ring_rd + 1) % DEPTH;
      n_events++;
    end
    pending_results.push_back(res);
  endfunction

  // driver: holds a request until it is taken, then maybe idles, then offers the next
  always @(posedge clk) begin : drv_blk
    button_req_t nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
      reset_shadow();
    end else begin
      // register writes land in the shadow at the transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_KEY_CODE:     key_sh = cfg_data[KEY_W-1:0];
          CFG_PRESS_MIN:    pmin_sh = cfg_data[KEY_W-1:0];
          CFG_HOLD_TICKS:   hold_sh = cfg_data;
          CFG_REPEAT_TICKS: rpt_sh = cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        predict_event_word(in_req_type, in_pin_level);
        n_taken++;
      end
      // a stalled request stays on the bus untouched
      if (!in_push || !in_full) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_push      <= 1'b1;
          in_req_type  <= nxt.req;
          in_pin_level <= nxt.pin;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result transfer with the oldest prediction
  always @(posedge clk) begin : mon_blk
    res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual key_word %h was_empty %b",
                   $time, out_key_word, out_was_empty);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          n_results++;
          if (out_key_word !== want.key_word) begin
            $display("%0t: key_word mismatch: expected %h, actual %h",
                     $time, want.key_word, out_key_word);
            n_errors++;
          end
          if (out_was_empty !== want.was_empty) begin
            $display("%0t: was_empty mismatch: expected %b, actual %b",
                     $time, want.was_empty, out_was_empty);
            n_errors++;
          end
        end
      end
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_req(logic req, logic pin);
    button_req_t r;
    r.req = req;
    r.pin = pin;
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  task automatic hold_button(int len);
    repeat (len) add_req(REQ_TICK, PIN_PRESSED);
    add_req(REQ_TICK, PIN_RELEASED);
  endtask

  task automatic read_events(int n);
    repeat (n) add_req(REQ_READ, 1'($urandom_range(1)));
  endtask

  // returns at a clock edge once every request has been taken and answered
  task automatic wait_drained();
    do @(posedge clk);
    while (n_taken != n_queued || pending_results.size() != 0);
  endtask

  // one register write; valid stays high so back to back writes need no gap
  task automatic write_reg(cfg_idx_t idx, logic [TICK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // new setting for all four registers, written only with the block drained
  task automatic set_regs(int key, int pmin, int hold, int rpt);
    wait_drained();
    // upper data bit is don't care for the 8-bit registers
    write_reg(CFG_KEY_CODE, {1'($urandom_range(1)), KEY_W'(key)});
    write_reg(CFG_PRESS_MIN, {1'($urandom_range(1)), KEY_W'(pmin)});
    write_reg(CFG_HOLD_TICKS, TICK_W'(hold));
    write_reg(CFG_REPEAT_TICKS, TICK_W'(rpt));
    cfg_valid <= 1'b0;
    n_settings++;
    // rotate through the idle patterns, one per setting
    case (n_settings % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 16; recv_stall_pct = 16; end
    endcase
  endtask

  // mostly whole presses with random length, then reads; some noise and empty reads
  task automatic random_items(int n, int max_press);
    int start;
    int kind;
    start = n_queued;
    while (n_queued - start < n) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        hold_button($urandom_range(1, max_press));
        if ($urandom_range(1)) add_req(REQ_TICK, PIN_RELEASED);
        read_events($urandom_range(0, 6));
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 8)) add_req(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        read_events($urandom_range(1, 6));
      end
    end
  endtask

  // press long enough to reach long mode and run past the counter fold
  function automatic int press_span(int hold, int rpt);
    return 2 * hold + 2 * rpt + 4;
  endfunction

  initial begin : stim_blk
    int key;
    int hold;
    int rpt;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: empty reads, presses at and just over the minimum
    read_events(2);
    add_req(REQ_TICK, PIN_RELEASED);
    hold_button(2);
    hold_button(3);
    read_events(2);
    hold_button(1);
    hold_button(4);
    read_events(2);

    // small hold and repeat so long presses and both repeat codes show up often
    hold = $urandom_range(4, 12);
    rpt = $urandom_range(1, 5);
    set_regs($urandom_range(1, 255), 0, hold, rpt);
    hold_button(press_span(hold, rpt));
    read_events(12);
    random_items(50, press_span(hold, rpt));

    // zero key code: short press gives nothing, repeats still queue
    set_regs(0, 0, 3, 2);
    hold_button(2);
    read_events(1);
    hold_button(12);
    read_events(6);
    random_items(30, press_span(3, 2));

    // top of every register range: a press just over the largest minimum
    set_regs(255, 255, 511, 511);
    hold_button(256);
    read_events(2);
    hold_button(5);
    read_events(1);

    // hold of one tick: a press can never start
    set_regs(1, 0, 1, 1);
    hold_button(5);
    read_events(1);

    // zero repeat period: long mode is silent
    set_regs(1, 0, 3, 0);
    hold_button(12);
    read_events(2);
    hold_button(2);
    read_events(2);

    // repeat every tick with no reads, so the ring overruns and wraps
    set_regs($urandom_range(1, 255), 0, 2, 1);
    hold_button(40);
    read_events(20);
    random_items(40, press_span(2, 1));

    // random settings
    repeat (3) begin
      key = $urandom_range(1, 255);
      hold = $urandom_range(2, 24);
      rpt = $urandom_range(1, 8);
      set_regs(key, $urandom_range(0, 4), hold, rpt);
      random_items(40, press_span(hold, rpt));
    end

    // let the pipe drain; a stray late result is still caught by the monitor
    wait_drained();
    repeat (20) @(posedge clk);
    $display("%0d register settings, %0d results checked: %0d events read, %0d empty reads",
             n_settings, n_results, n_events, n_empty);
    $display("event ring overran %0d times", n_wraps);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
